// ===== hdl/ssfs_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfs_pkg
// Types and constants shared by the supply start-up and fault supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfs_pkg;

	localparam int MODE_W = 3;

	localparam logic [MODE_W-1:0] MODE_WAIT        = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TEST        = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OPERATE     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FAULT       = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NO_RECOVERY = 3'd4;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TEST_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LED_HALF     = 2'd2;

	localparam logic [15:0] TEST_TICKS_RST   = 16'd1000;
	localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd5;
	localparam logic [7:0]  LED_HALF_RST     = 8'd50;

	typedef struct packed {
		logic tick;
		logic configured;
		logic heater_over_voltage;
		logic temperature_trip;
		logic link_fault;
		logic analog_limit_trip;
	} ssfs_in_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              supply_enable;
		logic              not_operating;
		logic              limits_armed;
		logic              power_led;
		logic              refresh_pin;
		logic [7:0]        attempt_count;
		logic              fault_now;
		logic              heater_ov_latched;
		logic              temperature_latched;
	} ssfs_out_t;

	typedef struct packed {
		logic [15:0] power_up_test_ticks;
		logic [7:0]  max_restart_attempts;
		logic [7:0]  led_half_period;
	} ssfs_cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [7:0]        attempts;
		logic [15:0]       test_timer;
		logic [7:0]        led_count;
		logic              led_level;
		logic              refresh_level;
		logic              fault_flag;
		logic [1:0]        latched_trips;
	} ssfs_state_t;

endpackage

`default_nettype wire

// ===== hdl/ssfs_step.sv =====
// ----------------------------------------------------------------------------
// ssfs_step
// Next-state and result logic for one main-loop pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfs_step (
	input  ssfs_pkg::ssfs_state_t cur,
	input  ssfs_pkg::ssfs_in_t    item,
	input  ssfs_pkg::ssfs_cfg_t   cfg,
	output ssfs_pkg::ssfs_state_t nxt,
	output ssfs_pkg::ssfs_out_t   res
);
	import ssfs_pkg::*;

	logic armed_start;
	logic armed_end;

	always_comb begin
		nxt = cur;
		armed_start = (cur.mode == MODE_TEST) || (cur.mode == MODE_OPERATE);

		if (item.heater_over_voltage) begin
			nxt.latched_trips[0] = 1'b1;
			nxt.fault_flag = 1'b1;
		end
		if (item.temperature_trip) begin
			nxt.latched_trips[1] = 1'b1;
			nxt.fault_flag = 1'b1;
		end

		if (item.tick) begin
			if (cur.test_timer != 16'hFFFF) begin
				nxt.test_timer = cur.test_timer + 16'd1;
			end
			if (cur.led_count != 8'hFF) begin
				nxt.led_count = cur.led_count + 8'd1;
			end
			if (nxt.led_count >= cfg.led_half_period) begin
				nxt.led_count = 8'd0;
				nxt.led_level = ~cur.led_level;
			end
			nxt.refresh_level = ~cur.refresh_level;
			nxt.fault_flag = item.heater_over_voltage | item.temperature_trip |
				item.link_fault | (armed_start & item.analog_limit_trip);
		end

		case (cur.mode)
			MODE_WAIT: begin
				if (item.configured) begin
					if (cur.attempts != 8'hFF) begin
						nxt.attempts = cur.attempts + 8'd1;
					end
					nxt.test_timer = 16'd0;
					nxt.mode = MODE_TEST;
				end
			end
			MODE_TEST: begin
				if (nxt.fault_flag) begin
					nxt.mode = (cur.attempts <= cfg.max_restart_attempts) ?
						MODE_FAULT : MODE_NO_RECOVERY;
				end else if (nxt.test_timer >= cfg.power_up_test_ticks) begin
					nxt.mode = MODE_OPERATE;
					nxt.attempts = 8'd0;
					nxt.latched_trips = 2'b00;
				end
			end
			MODE_OPERATE: begin
				if (nxt.fault_flag) begin
					nxt.mode = MODE_FAULT;
				end
			end
			MODE_FAULT: begin
				if (!nxt.fault_flag) begin
					nxt.mode = MODE_WAIT;
				end
			end
			default: begin
				nxt.mode = MODE_NO_RECOVERY;
			end
		endcase

		armed_end = (nxt.mode == MODE_TEST) || (nxt.mode == MODE_OPERATE);
		res.mode = nxt.mode;
		res.supply_enable = armed_end;
		res.not_operating = (nxt.mode != MODE_OPERATE);
		res.limits_armed = armed_end;
		res.power_led = nxt.led_level;
		res.refresh_pin = nxt.refresh_level;
		res.attempt_count = nxt.attempts;
		res.fault_now = nxt.fault_flag;
		res.heater_ov_latched = nxt.latched_trips[0];
		res.temperature_latched = nxt.latched_trips[1];
	end

endmodule

`default_nettype wire

// ===== hdl/supply_startup_fault_supervisor_top.sv =====
// ----------------------------------------------------------------------------
// supply_startup_fault_supervisor_top
// Start-up sequencing and fault supervision for a heater and magnet supply.
// ----------------------------------------------------------------------------
// an accepted pass is registered; its result beat shows on the output in the next cycle
// throughput: one pass per cycle while not stalled, set by the single state update per beat
// in_stall rises only while a held result beat is stalled on the output
// reset clears mode to waiting, all counters and flags, and loads the
// register defaults (1000 test ticks, 5 attempts, 50 tick led half period)
`default_nettype none

module supply_startup_fault_supervisor_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  ssfs_pkg::ssfs_in_t                   in_data,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output ssfs_pkg::ssfs_out_t                  out_data,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [ssfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [ssfs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ssfs_pkg::*;

	ssfs_cfg_t   cfg_q;
	ssfs_state_t state_q;
	ssfs_state_t state_nxt;
	ssfs_out_t   res;
	ssfs_out_t   out_data_q;
	logic        out_valid_q;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign in_stall = out_valid_q & out_stall;
	assign accept = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	ssfs_step u_step (
		.cur  (state_q),
		.item (in_data),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up_test_ticks <= TEST_TICKS_RST;
			cfg_q.max_restart_attempts <= MAX_ATTEMPTS_RST;
			cfg_q.led_half_period <= LED_HALF_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEST_TICKS:   cfg_q.power_up_test_ticks <= cfg_data;
				REG_MAX_ATTEMPTS: cfg_q.max_restart_attempts <= cfg_data[7:0];
				REG_LED_HALF:     cfg_q.led_half_period <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, held while the beat is stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res;
		end
	end

	a_no_recovery_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_NO_RECOVERY |=> state_q.mode == MODE_NO_RECOVERY)
		else $error("left no recovery mode");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty result register");

	a_enable_tracks_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.supply_enable ==
			(out_data_q.mode == MODE_TEST || out_data_q.mode == MODE_OPERATE)))
		else $error("supply enable disagrees with mode");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_data_q.mode == state_q.mode &&
			out_data_q.attempt_count == state_q.attempts))
		else $error("result beat out of step with state");

endmodule

`default_nettype wire
